### hw/rtl/htw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htw_pkg: shared types and constants of the timing wheel
// Wheel geometry, beat and command structs, sequencer states and slot math.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int LOW_BITS   = 8;
  localparam int HIGH_BITS  = 6;
  localparam int POOL_SIZE  = 64;

  localparam int LOW_SIZE   = 1 << LOW_BITS;
  localparam int HIGH_SIZE  = 1 << HIGH_BITS;
  localparam int SLOT_COUNT = LOW_SIZE + 4 * HIGH_SIZE;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int ID_W       = $clog2(POOL_SIZE);
  localparam int NEXT_W     = $clog2(POOL_SIZE + 1);
  localparam int PREV_W     = $clog2(POOL_SIZE + SLOT_COUNT + 1);
  localparam int CLR_COUNT  = (SLOT_COUNT > POOL_SIZE) ? SLOT_COUNT : POOL_SIZE;
  localparam int CLR_W      = $clog2(CLR_COUNT) + 1;

  localparam logic [NEXT_W-1:0] NONE_NEXT = NEXT_W'(POOL_SIZE);
  localparam logic [PREV_W-1:0] NONE_PREV = PREV_W'(POOL_SIZE + SLOT_COUNT);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_KILL  = 2'd2;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_START,
    CMD_KILL
  } cmd_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [5:0]         timer_id;
    logic [31:0]        interval;
    logic signed [15:0] repeat_count;
  } in_beat_t;

  typedef struct packed {
    logic       fired;
    logic [5:0] fired_id;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    cmd_e            kind;
    logic [ID_W-1:0] id;
    logic [31:0]     interval;
    logic [15:0]     rpt;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_UNLINK_RD,
    S_UNLINK_WR,
    S_UNLINK_CLR,
    S_START,
    S_FSLOT,
    S_FREAD,
    S_FLINK,
    S_FPREV,
    S_TICK,
    S_CASC,
    S_DET_RD,
    S_DET_GET,
    S_WALK_RD,
    S_WALK_EXE,
    S_WALK_NEXT,
    S_FIRE_BEGIN,
    S_DONE
  } state_e;

  function automatic logic [HIGH_BITS-1:0] level_index(input logic [31:0] t,
                                                       input logic [1:0] lvl);
    logic [63:0]          w;
    logic [HIGH_BITS-1:0] r;
    w = {32'd0, t};
    r = '0;
    for (int j = 0; j < 4; j++) begin
      if (lvl == 2'(j)) r = HIGH_BITS'(w >> (LOW_BITS + j * HIGH_BITS));
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] level_base(input logic [1:0] lvl);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int j = 0; j < 4; j++) begin
      if (lvl == 2'(j)) r = SLOT_W'(LOW_SIZE + j * HIGH_SIZE);
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] file_slot(input logic [31:0] due,
                                                  input logic [31:0] now);
    logic [31:0]       diff;
    logic [1:0]        lvl;
    logic [SLOT_W-1:0] r;
    diff = due - now;
    lvl  = 2'd0;
    for (int j = 1; j < 4; j++) begin
      if ({32'd0, diff} >= (64'd1 << (LOW_BITS + j * HIGH_BITS))) lvl = 2'(j);
    end
    if (diff[31]) begin
      r = SLOT_W'(now[LOW_BITS-1:0]);
    end else if (diff < 32'(LOW_SIZE)) begin
      r = SLOT_W'(due[LOW_BITS-1:0]);
    end else begin
      r = level_base(lvl) + SLOT_W'(level_index(due, lvl));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/htw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htw_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### hw/rtl/htw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htw_front: input decode and command queue
// Classifies each input beat into a command and holds up to two commands
// for the sequencer.
// ----------------------------------------------------------------------------
module htw_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire htw_pkg::in_beat_t in_data_i,
  input  wire htw_pkg::status_t  status_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output htw_pkg::cmd_t          cmd_o
);

  htw_pkg::cmd_t buf_q [2];
  htw_pkg::cmd_t cmd_new;
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop, id_ok;

  assign id_ok = {1'b0, in_data_i.timer_id} < 7'(htw_pkg::POOL_SIZE);

  always_comb begin
    cmd_new.id       = htw_pkg::ID_W'(in_data_i.timer_id);
    cmd_new.interval = in_data_i.interval;
    cmd_new.rpt      = in_data_i.repeat_count;
    unique case (in_data_i.op)
      htw_pkg::OP_TICK:  cmd_new.kind = htw_pkg::CMD_TICK;
      htw_pkg::OP_START: cmd_new.kind = id_ok ? htw_pkg::CMD_START : htw_pkg::CMD_NOP;
      htw_pkg::OP_KILL:  cmd_new.kind = id_ok ? htw_pkg::CMD_KILL : htw_pkg::CMD_NOP;
      default:           cmd_new.kind = htw_pkg::CMD_NOP;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2) && !status_i.clearing;
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= cmd_new;
  end

endmodule
`default_nettype wire

### hw/rtl/htw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htw_back: wheel sequencer
// Runs start, kill and tick commands against the slot and link memories,
// and drives the result register.
// ----------------------------------------------------------------------------
module htw_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  output logic                    cmd_ready_o,
  input  wire htw_pkg::cmd_t      cmd_i,
  output htw_pkg::status_t        status_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output htw_pkg::out_beat_t      out_data_o
);

  localparam int SW = htw_pkg::SLOT_W;
  localparam int IW = htw_pkg::ID_W;
  localparam int NW = htw_pkg::NEXT_W;
  localparam int PW = htw_pkg::PREV_W;
  localparam int HIGH_BITS_W = htw_pkg::HIGH_BITS;

  htw_pkg::state_e    state_q, state_d;
  htw_pkg::cmd_t      cmd_q, cmd_d;
  htw_pkg::out_beat_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        ct_q, ct_d;
  logic [htw_pkg::CLR_W-1:0] clr_q, clr_d;
  logic [1:0]         lvl_q, lvl_d;
  logic               fire_mode_q, fire_mode_d;
  logic               ret_walk_q, ret_walk_d;
  logic               ix_nz_q, ix_nz_d;
  logic               pend_valid_q, pend_valid_d;
  logic [IW-1:0]      pend_id_q, pend_id_d;
  logic [IW-1:0]      t_q, t_d;
  logic [SW-1:0]      slot_q, slot_d;
  logic [31:0]        due_q, due_d;
  logic [NW-1:0]      nx_q, nx_d;
  logic [NW-1:0]      h_q, h_d;

  logic          head_we;
  logic [SW-1:0] head_waddr;
  logic [NW-1:0] head_wdata, head_rd;
  logic          nxt_we;
  logic [IW-1:0] nxt_waddr;
  logic [NW-1:0] nxt_wdata, nxt_rd;
  logic          prv_we;
  logic [IW-1:0] prv_waddr;
  logic [PW-1:0] prv_wdata, prv_rd;
  logic          due_we, per_we, rem_we;
  logic [31:0]   due_wdata, per_wdata, due_rd, per_rd;
  logic [15:0]   rem_wdata, rem_rd;

  logic out_free, fire_w, exe_stall, casc_more, is_start;
  logic [HIGH_BITS_W-1:0] ix_w;

  htw_ram #(.WIDTH(NW), .DEPTH(htw_pkg::SLOT_COUNT)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(slot_q), .rdata_o(head_rd));
  htw_ram #(.WIDTH(NW), .DEPTH(htw_pkg::POOL_SIZE)) u_next (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .raddr_i(t_q), .rdata_o(nxt_rd));
  htw_ram #(.WIDTH(PW), .DEPTH(htw_pkg::POOL_SIZE)) u_prev (
    .clk_i, .we_i(prv_we), .waddr_i(prv_waddr), .wdata_i(prv_wdata),
    .raddr_i(t_q), .rdata_o(prv_rd));
  htw_ram #(.WIDTH(32), .DEPTH(htw_pkg::POOL_SIZE)) u_due (
    .clk_i, .we_i(due_we), .waddr_i(t_q), .wdata_i(due_wdata),
    .raddr_i(t_q), .rdata_o(due_rd));
  htw_ram #(.WIDTH(32), .DEPTH(htw_pkg::POOL_SIZE)) u_period (
    .clk_i, .we_i(per_we), .waddr_i(t_q), .wdata_i(per_wdata),
    .raddr_i(t_q), .rdata_o(per_rd));
  htw_ram #(.WIDTH(16), .DEPTH(htw_pkg::POOL_SIZE)) u_remain (
    .clk_i, .we_i(rem_we), .waddr_i(t_q), .wdata_i(rem_wdata),
    .raddr_i(t_q), .rdata_o(rem_rd));

  assign out_free    = !out_valid_q || out_ready_i;
  assign fire_w      = rem_rd[15] || (rem_rd != 16'd0);
  assign exe_stall   = fire_mode_q && fire_w && pend_valid_q && !out_free;
  assign casc_more   = !fire_mode_q && !ix_nz_q && (lvl_q != 2'd3);
  assign is_start    = cmd_q.kind == htw_pkg::CMD_START;
  assign ix_w        = htw_pkg::level_index(ct_q, lvl_q);
  assign cmd_ready_o = state_q == htw_pkg::S_IDLE;
  assign status_o.clearing = state_q == htw_pkg::S_CLEAR;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      htw_pkg::S_CLEAR: begin
        if (clr_q == htw_pkg::CLR_W'(htw_pkg::CLR_COUNT - 1)) state_d = htw_pkg::S_IDLE;
      end
      htw_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            htw_pkg::CMD_TICK:  state_d = htw_pkg::S_TICK;
            htw_pkg::CMD_START: state_d = htw_pkg::S_UNLINK_RD;
            htw_pkg::CMD_KILL:  state_d = htw_pkg::S_UNLINK_RD;
            default:            state_d = htw_pkg::S_DONE;
          endcase
        end
      end
      htw_pkg::S_UNLINK_RD: state_d = htw_pkg::S_UNLINK_WR;
      htw_pkg::S_UNLINK_WR: begin
        if (prv_rd < htw_pkg::NONE_PREV) state_d = htw_pkg::S_UNLINK_CLR;
        else state_d = is_start ? htw_pkg::S_START : htw_pkg::S_DONE;
      end
      htw_pkg::S_UNLINK_CLR: state_d = is_start ? htw_pkg::S_START : htw_pkg::S_DONE;
      htw_pkg::S_START:      state_d = htw_pkg::S_FSLOT;
      htw_pkg::S_FSLOT:      state_d = htw_pkg::S_FREAD;
      htw_pkg::S_FREAD:      state_d = htw_pkg::S_FLINK;
      htw_pkg::S_FLINK: begin
        if (head_rd < htw_pkg::NONE_NEXT) state_d = htw_pkg::S_FPREV;
        else state_d = ret_walk_q ? htw_pkg::S_WALK_NEXT : htw_pkg::S_DONE;
      end
      htw_pkg::S_FPREV: state_d = ret_walk_q ? htw_pkg::S_WALK_NEXT : htw_pkg::S_DONE;
      htw_pkg::S_TICK: begin
        if (ct_q[htw_pkg::LOW_BITS-1:0] == '0) state_d = htw_pkg::S_CASC;
        else state_d = htw_pkg::S_FIRE_BEGIN;
      end
      htw_pkg::S_CASC:   state_d = htw_pkg::S_DET_RD;
      htw_pkg::S_DET_RD: state_d = htw_pkg::S_DET_GET;
      htw_pkg::S_DET_GET, htw_pkg::S_WALK_NEXT: begin
        if ((state_q == htw_pkg::S_DET_GET) ? (head_rd < htw_pkg::NONE_NEXT)
                                            : (nx_q < htw_pkg::NONE_NEXT)) begin
          state_d = htw_pkg::S_WALK_RD;
        end else if (fire_mode_q) begin
          state_d = htw_pkg::S_DONE;
        end else if (casc_more) begin
          state_d = htw_pkg::S_CASC;
        end else begin
          state_d = htw_pkg::S_FIRE_BEGIN;
        end
      end
      htw_pkg::S_WALK_RD: state_d = htw_pkg::S_WALK_EXE;
      htw_pkg::S_WALK_EXE: begin
        if (!fire_mode_q) state_d = htw_pkg::S_FSLOT;
        else if (!exe_stall) state_d = fire_w ? htw_pkg::S_FSLOT : htw_pkg::S_WALK_NEXT;
      end
      htw_pkg::S_FIRE_BEGIN: state_d = htw_pkg::S_DET_RD;
      htw_pkg::S_DONE: begin
        if (out_free) state_d = htw_pkg::S_IDLE;
      end
      default: state_d = htw_pkg::S_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    cmd_d        = cmd_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ct_d         = ct_q;
    clr_d        = clr_q;
    lvl_d        = lvl_q;
    fire_mode_d  = fire_mode_q;
    ret_walk_d   = ret_walk_q;
    ix_nz_d      = ix_nz_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    t_d          = t_q;
    slot_d       = slot_q;
    due_d        = due_q;
    nx_d         = nx_q;
    h_d          = h_q;
    head_we      = 1'b0;
    head_waddr   = slot_q;
    head_wdata   = htw_pkg::NONE_NEXT;
    nxt_we       = 1'b0;
    nxt_waddr    = t_q;
    nxt_wdata    = htw_pkg::NONE_NEXT;
    prv_we       = 1'b0;
    prv_waddr    = t_q;
    prv_wdata    = htw_pkg::NONE_PREV;
    due_we       = 1'b0;
    due_wdata    = due_rd + per_rd;
    per_we       = 1'b0;
    per_wdata    = cmd_q.interval;
    rem_we       = 1'b0;
    rem_wdata    = rem_rd - 16'd1;
    unique case (state_q)
      htw_pkg::S_CLEAR: begin
        clr_d      = clr_q + htw_pkg::CLR_W'(1);
        head_we    = clr_q < htw_pkg::CLR_W'(htw_pkg::SLOT_COUNT);
        head_waddr = clr_q[SW-1:0];
        nxt_we     = clr_q < htw_pkg::CLR_W'(htw_pkg::POOL_SIZE);
        nxt_waddr  = clr_q[IW-1:0];
        prv_we     = nxt_we;
        prv_waddr  = clr_q[IW-1:0];
      end
      htw_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          t_d   = cmd_i.id;
        end
      end
      htw_pkg::S_UNLINK_WR: begin
        if (prv_rd < htw_pkg::NONE_PREV) begin
          if (prv_rd < PW'(htw_pkg::POOL_SIZE)) begin
            nxt_we    = 1'b1;
            nxt_waddr = IW'(prv_rd);
            nxt_wdata = nxt_rd;
          end else begin
            head_we    = 1'b1;
            head_waddr = SW'(prv_rd - PW'(htw_pkg::POOL_SIZE));
            head_wdata = nxt_rd;
          end
          prv_we    = nxt_rd < htw_pkg::NONE_NEXT;
          prv_waddr = IW'(nxt_rd);
          prv_wdata = prv_rd;
        end
      end
      htw_pkg::S_UNLINK_CLR: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
      end
      htw_pkg::S_START: begin
        per_we     = 1'b1;
        rem_we     = 1'b1;
        rem_wdata  = cmd_q.rpt;
        due_we     = 1'b1;
        due_wdata  = ct_q + cmd_q.interval;
        due_d      = ct_q + cmd_q.interval;
        ret_walk_d = 1'b0;
      end
      htw_pkg::S_FSLOT: slot_d = htw_pkg::file_slot(due_q, ct_q);
      htw_pkg::S_FLINK: begin
        h_d        = head_rd;
        nxt_we     = 1'b1;
        nxt_wdata  = head_rd;
        prv_we     = 1'b1;
        prv_wdata  = PW'(htw_pkg::POOL_SIZE) + PW'(slot_q);
        head_we    = 1'b1;
        head_wdata = NW'(t_q);
      end
      htw_pkg::S_FPREV: begin
        prv_we    = 1'b1;
        prv_waddr = IW'(h_q);
        prv_wdata = PW'(t_q);
      end
      htw_pkg::S_TICK: lvl_d = 2'd0;
      htw_pkg::S_CASC: begin
        slot_d      = htw_pkg::level_base(lvl_q) + SW'(ix_w);
        ix_nz_d     = ix_w != '0;
        fire_mode_d = 1'b0;
      end
      htw_pkg::S_DET_RD: head_we = 1'b1;
      htw_pkg::S_DET_GET, htw_pkg::S_WALK_NEXT: begin
        if (state_q == htw_pkg::S_DET_GET) t_d = IW'(head_rd);
        else t_d = IW'(nx_q);
        if (((state_q == htw_pkg::S_DET_GET) ? (head_rd >= htw_pkg::NONE_NEXT)
                                             : (nx_q >= htw_pkg::NONE_NEXT))
            && casc_more) begin
          lvl_d = lvl_q + 2'd1;
        end
      end
      htw_pkg::S_WALK_EXE: begin
        if (!exe_stall) begin
          nx_d       = nxt_rd;
          nxt_we     = 1'b1;
          prv_we     = 1'b1;
          ret_walk_d = 1'b1;
          if (!fire_mode_q) begin
            due_d = due_rd;
          end else begin
            rem_we = !rem_rd[15];
            if (fire_w) begin
              due_we       = 1'b1;
              due_d        = due_rd + per_rd;
              pend_valid_d = 1'b1;
              pend_id_d    = t_q;
              if (pend_valid_q) begin
                out_valid_d    = 1'b1;
                out_d.fired    = 1'b1;
                out_d.fired_id = 6'(pend_id_q);
                out_d.last     = 1'b0;
              end
            end
          end
        end
      end
      htw_pkg::S_FIRE_BEGIN: begin
        slot_d      = SW'(ct_q[htw_pkg::LOW_BITS-1:0]);
        ct_d        = ct_q + 32'd1;
        fire_mode_d = 1'b1;
      end
      htw_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.fired    = pend_valid_q;
          out_d.fired_id = pend_valid_q ? 6'(pend_id_q) : 6'd0;
          out_d.last     = 1'b1;
          pend_valid_d   = 1'b0;
          fire_mode_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= htw_pkg::S_CLEAR;
      out_valid_q  <= 1'b0;
      ct_q         <= 32'd0;
      clr_q        <= '0;
      lvl_q        <= 2'd0;
      fire_mode_q  <= 1'b0;
      ret_walk_q   <= 1'b0;
      ix_nz_q      <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      ct_q         <= ct_d;
      clr_q        <= clr_d;
      lvl_q        <= lvl_d;
      fire_mode_q  <= fire_mode_d;
      ret_walk_q   <= ret_walk_d;
      ix_nz_q      <= ix_nz_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    out_q     <= out_d;
    pend_id_q <= pend_id_d;
    t_q       <= t_d;
    slot_q    <= slot_d;
    due_q     <= due_d;
    nx_q      <= nx_d;
    h_q       <= h_d;
  end

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == htw_pkg::S_CLEAR |-> !out_valid_q && !pend_valid_q)
    else $error("result during clearing pass");

  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (ct_q == $past(ct_q)) || (ct_q == $past(ct_q) + 32'd1))
    else $error("time moved by more than one");

  a_pend_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> fire_mode_q)
    else $error("pending firing outside fire walk");

  a_fired_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.fired |-> {1'b0, out_q.fired_id} < 7'(htw_pkg::POOL_SIZE))
    else $error("fired id out of pool");

endmodule
`default_nettype wire

### hw/rtl/hierarchical_timing_wheel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hierarchical_timing_wheel: five-level timing wheel over a timer pool
// After reset a clearing pass over the slot heads (512 by default) and pool
// links runs before the first beat is taken. Once the sequencer takes a
// command, a kill unlinks the timer if it is linked; a start also writes
// its period, repeat count and due time and files it at the head of its
// slot. A tick cascades wheel levels when the low index wraps, then walks
// the current low slot, dropping spent timers and refiling or firing the
// rest; the walk runs through the registered-read slot and link memories.
// A full result register can stall the walk. Each input beat yields one or
// more result beats, the final one flagged last; a two-deep command queue
// and a result register decouple both sides.
// ----------------------------------------------------------------------------
module hierarchical_timing_wheel (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire htw_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output htw_pkg::out_beat_t      out_data_o
);

  htw_pkg::cmd_t    cmd;
  htw_pkg::status_t status;
  logic             cmd_valid, cmd_ready;

  htw_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .status_i(status), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready),
    .cmd_o(cmd));

  htw_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .status_o(status), .out_valid_o, .out_ready_i, .out_data_o);

endmodule
`default_nettype wire

### tb/hierarchical_timing_wheel_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_timing_wheel_tb: self-checking bench for the timing wheel
// Drives start, kill, tick and bad commands. A behavioral copy of the wheel
// predicts every result beat, and each beat out of the block is checked
// against it in order. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module hierarchical_timing_wheel_tb;

  localparam int WDOG_LIMIT = 20000;
  localparam logic [1:0] OP_BAD = 2'd3;
  localparam int POOL = htw_pkg::POOL_SIZE;
  localparam int SLOTS = htw_pkg::SLOT_COUNT;
  localparam int LB = htw_pkg::LOW_BITS;
  localparam int HB = htw_pkg::HIGH_BITS;
  localparam int LSZ = htw_pkg::LOW_SIZE;
  localparam int HSZ = htw_pkg::HIGH_SIZE;
  localparam int NIL_N = POOL;
  localparam int NIL_P = POOL + SLOTS;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  htw_pkg::in_beat_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  htw_pkg::out_beat_t out_data_o;

  hierarchical_timing_wheel uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  // wheel state mirror
  logic [31:0] now_ms;
  logic [31:0] due_ms [POOL];
  logic [31:0] per_ms [POOL];
  logic [15:0] left_cnt [POOL];
  int          slot_first [SLOTS];
  int          link_nx [POOL];
  int          link_pv [POOL];

  htw_pkg::out_beat_t pending_fires[$];
  int          errors;
  int          idle_cycles;
  bit          quiet;
  int          out_stall;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int home_slot(int t);
    logic [31:0] diff;
    int          lvl;
    diff = due_ms[t] - now_ms;
    if (diff[31]) return int'(now_ms[LB-1:0]);
    if (diff < 32'(LSZ)) return int'(due_ms[t][LB-1:0]);
    lvl = 1;
    while (lvl < 4 && {32'd0, diff} >= (64'd1 << (LB + lvl * HB))) lvl++;
    return LSZ + (lvl - 1) * HSZ +
           int'((due_ms[t] >> (LB + (lvl - 1) * HB)) & 32'(HSZ - 1));
  endfunction

  function automatic void file_at_head(int t);
    int s;
    s = home_slot(t);
    link_pv[t] = POOL + s;
    link_nx[t] = slot_first[s];
    if (slot_first[s] < POOL) link_pv[slot_first[s]] = t;
    slot_first[s] = t;
  endfunction

  function automatic void drop_timer(int t);
    int p, n;
    p = link_pv[t];
    n = link_nx[t];
    if (p >= NIL_P) return;
    if (p < POOL) link_nx[p] = n;
    else slot_first[p - POOL] = n;
    if (n < POOL) link_pv[n] = p;
    link_pv[t] = NIL_P;
    link_nx[t] = NIL_N;
  endfunction

  function automatic void refile_slot(int s);
    int t, nx;
    t = slot_first[s];
    slot_first[s] = NIL_N;
    while (t < POOL) begin
      nx = link_nx[t];
      link_nx[t] = NIL_N;
      link_pv[t] = NIL_P;
      file_at_head(t);
      t = nx;
    end
  endfunction

  function automatic void wheel_apply(htw_pkg::in_beat_t b);
    int                 idx, t, nx, n, ix;
    bit                 go;
    htw_pkg::out_beat_t r;
    n = 0;
    if (b.op == htw_pkg::OP_TICK) begin
      idx = int'(now_ms[LB-1:0]);
      if (idx == 0) begin
        for (int k = 0; k < 4; k++) begin
          ix = int'(({32'd0, now_ms} >> (LB + k * HB)) & 64'(HSZ - 1));
          refile_slot(LSZ + k * HSZ + ix);
          if (ix != 0) break;
        end
      end
      now_ms = now_ms + 32'd1;
      t = slot_first[idx];
      slot_first[idx] = NIL_N;
      while (t < POOL) begin
        nx = link_nx[t];
        link_nx[t] = NIL_N;
        link_pv[t] = NIL_P;
        if (left_cnt[t][15]) begin
          go = 1'b1;
        end else begin
          go = (left_cnt[t] != 16'd0);
          left_cnt[t] = left_cnt[t] - 16'd1;
        end
        if (go && n < POOL) begin
          due_ms[t] = due_ms[t] + per_ms[t];
          file_at_head(t);
          r.fired = 1'b1;
          r.fired_id = 6'(t);
          r.last = 1'b0;
          pending_fires.push_back(r);
          n++;
        end
        t = nx;
      end
    end else if (b.op == htw_pkg::OP_START) begin
      drop_timer(int'(b.timer_id));
      per_ms[b.timer_id] = b.interval;
      left_cnt[b.timer_id] = b.repeat_count;
      due_ms[b.timer_id] = now_ms + b.interval;
      file_at_head(int'(b.timer_id));
    end else if (b.op == htw_pkg::OP_KILL) begin
      drop_timer(int'(b.timer_id));
    end
    if (n == 0) begin
      r = '{fired: 1'b0, fired_id: 6'd0, last: 1'b1};
      pending_fires.push_back(r);
    end else begin
      pending_fires[$].last = 1'b1;
    end
  endfunction

  task automatic send_beat(logic [1:0] op, logic [5:0] id, logic [31:0] ivl,
                           logic [15:0] rpt);
    htw_pkg::in_beat_t b;
    b.op = op;
    b.timer_id = id;
    b.interval = ivl;
    b.repeat_count = rpt;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    wheel_apply(b);
  endtask

  task automatic tick_n(int n);
    repeat (n) send_beat(htw_pkg::OP_TICK, 6'($urandom), $urandom, 16'($urandom));
  endtask

  task automatic test_directed();
    send_beat(OP_BAD, 6'd5, 32'hFFFF_FFFF, 16'hFFFF);
    send_beat(htw_pkg::OP_KILL, 6'd7, 32'd0, 16'd0);
    send_beat(htw_pkg::OP_START, 6'd0, 32'd0, 16'sd1);
    send_beat(htw_pkg::OP_START, 6'd63, 32'd2, -16'sd1);
    send_beat(htw_pkg::OP_START, 6'd1, 32'd1, 16'sd0);
    send_beat(htw_pkg::OP_START, 6'd2, 32'hFFFF_FFFF, 16'sd2);
    send_beat(htw_pkg::OP_START, 6'd3, 32'h7FFF_FFFF, 16'sh7FFF);
    send_beat(htw_pkg::OP_START, 6'd4, 32'h8000_0000, 16'sd3);
    tick_n(3);
    send_beat(htw_pkg::OP_START, 6'd63, 32'd3, 16'sd2);
    send_beat(htw_pkg::OP_KILL, 6'd2, 32'd0, 16'd0);
    tick_n(4);
    send_beat(htw_pkg::OP_KILL, 6'd63, 32'd0, 16'd0);
    send_beat(OP_BAD, 6'd0, 32'd0, 16'd0);
    tick_n(2);
  endtask

  task automatic test_periodic();
    send_beat(htw_pkg::OP_START, 6'd10, 32'd20, 16'sd2);
    send_beat(htw_pkg::OP_START, 6'd11, 32'd300, 16'sd1);
    send_beat(htw_pkg::OP_START, 6'd12, 32'd5, -16'sd1);
    send_beat(htw_pkg::OP_START, 6'd13, 32'd256, 16'sd1);
    send_beat(htw_pkg::OP_START, 6'd14, 32'd1, 16'sd3);
    tick_n(34);
    send_beat(htw_pkg::OP_KILL, 6'd12, 32'd0, 16'd0);
  endtask

  task automatic test_random(int n);
    int          sel;
    logic [31:0] ivl;
    logic [15:0] rpt;
    for (int i = 0; i < n; i++) begin
      if (i == n - 30) quiet = 1'b1;
      sel = $urandom_range(0, 19);
      ivl = $urandom_range(0, 40);
      rpt = 16'($urandom_range(0, 6)) - 16'd1;
      if (sel < 9) begin
        send_beat(htw_pkg::OP_TICK, 6'($urandom), $urandom, 16'($urandom));
      end else if (sel < 15) begin
        send_beat(htw_pkg::OP_START, 6'($urandom), ivl, rpt);
      end else if (sel < 17) begin
        send_beat(htw_pkg::OP_KILL, 6'($urandom), $urandom, 16'($urandom));
      end else if (sel < 18) begin
        send_beat(OP_BAD, 6'($urandom), $urandom, 16'($urandom));
      end else begin
        send_beat(htw_pkg::OP_START, 6'($urandom), $urandom, 16'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    errors = 0;
    quiet = 1'b0;
    now_ms = '0;
    for (int i = 0; i < POOL; i++) begin
      due_ms[i] = '0;
      per_ms[i] = '0;
      left_cnt[i] = '0;
      link_nx[i] = NIL_N;
      link_pv[i] = NIL_P;
    end
    for (int i = 0; i < SLOTS; i++) slot_first[i] = NIL_N;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_periodic();
    test_random(60);
    in_valid_i <= 1'b0;
    while (pending_fires.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial out_ready_i = 1'b0;
  initial out_stall = 0;

  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall = out_stall - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(0, 16);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    htw_pkg::out_beat_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_fires.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data_o);
        errors++;
      end else begin
        want = pending_fires.pop_front();
        if (out_data_o.fired !== want.fired) begin
          $error("fired: expected %0d, got %0d", want.fired, out_data_o.fired);
          errors++;
        end
        if (out_data_o.fired_id !== want.fired_id) begin
          $error("fired_id: expected %0d, got %0d", want.fired_id, out_data_o.fired_id);
          errors++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data_o.last);
          errors++;
        end
      end
    end
  end

  initial idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
